// ===== rtl/core/sipkm_pkg.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sipkm_pkg
// shared codes and widths for the screen idle and power key manager
// ----------------------------------------------------------------------------
package sipkm_pkg;

  localparam int unsigned TIMEOUT_W  = 24;
  localparam int unsigned CFG_DATA_W = 24;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned KIND_W     = 3;
  localparam int unsigned IN_DATA_W  = 8;
  localparam int unsigned OUT_DATA_W = 8;

  typedef enum logic [KIND_W-1:0] {
    KIND_TICK     = 3'd0,
    KIND_KEY      = 3'd1,
    KIND_MARK     = 3'd2,
    KIND_HOLD     = 3'd3,
    KIND_RELEASE  = 3'd4
  } kind_t;

  typedef enum logic [1:0] {
    KEV_OTHER     = 2'd0,
    KEV_CLICK     = 2'd1,
    KEV_LONG      = 2'd2,
    KEV_LONG_REL  = 2'd3
  } key_ev_t;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ENABLE    = 2'd0,
    REG_TIMEOUT   = 2'd1,
    REG_PREP_HOOK = 2'd2
  } reg_idx_t;

  typedef struct packed {
    logic    capture_page_active;
    logic    touch_pressed;
    key_ev_t key_event;
    logic    key_is_power;
  } item_t;

  typedef struct packed {
    logic power_off_request;
    logic shutdown_prepare;
    logic awaiting_release;
    logic screen_on;
  } result_t;

endpackage

// ===== rtl/core/screen_idle_and_power_key_manager.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// screen_idle_and_power_key_manager
// backlight, idle timeout, sleep hold and power key handling
//
// channel  dir  handshake         payload
// in_      in   tvalid / tready   tdata: event fields, tuser: kind
// out_     out  tvalid / tready   tdata: state and pulses after each word
// cfg_     in   valid / ready     index, data (cfg_ready always high)
//
// one word per cycle sustained while out_tready is high; an accepted word passes
// the input register, then the state update into the result register
// rst_n is synchronous, active low; resets state (screen lit), config and valids
// a stalled result holds the pipe; the input register still takes one word
// ----------------------------------------------------------------------------
module screen_idle_and_power_key_manager
  import sipkm_pkg::*;
#(
  parameter int unsigned IDLE_BITS = 24,
  parameter int unsigned HOLD_BITS = 8
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // [0] key_is_power, [2:1] key_event, [3] touch_pressed,
  // [4] capture_page_active, [7:5] zero
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // [2:0] kind
  input  logic [KIND_W-1:0]     in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // [0] screen_on, [1] awaiting_release, [2] shutdown_prepare,
  // [3] power_off_request, [7:4] zero
  output logic [OUT_DATA_W-1:0] out_tdata,
  input  logic                  cfg_valid,
  output logic                  cfg_ready,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_data
);

  localparam int unsigned CMP_W = (IDLE_BITS > TIMEOUT_W) ? IDLE_BITS : TIMEOUT_W;
  localparam logic [IDLE_BITS-1:0] IDLE_MAX = {IDLE_BITS{1'b1}};
  localparam logic [HOLD_BITS-1:0] HOLD_MAX = {HOLD_BITS{1'b1}};

  // config
  logic                 enable_r;
  logic [TIMEOUT_W-1:0] timeout_r;
  logic                 prep_hook_r;

  // state
  logic                 lit_r, lit_nxt;
  logic                 wait_r, wait_nxt;
  logic [IDLE_BITS-1:0] idle_r, idle_nxt;
  logic [HOLD_BITS-1:0] hold_r, hold_nxt;
  logic                 touch_r, touch_nxt;

  // pipe
  logic                 s1_valid_r;
  item_t                s1_item_r;
  logic [KIND_W-1:0]    s1_kind_r;
  logic                 out_valid_r;
  result_t              res_r, res_nxt;

  logic                 s1_adv;
  logic                 in_acc;

  assign cfg_ready  = 1'b1;
  assign s1_adv     = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready  = !s1_valid_r || s1_adv;
  assign in_acc     = in_tvalid && in_tready;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = {{(OUT_DATA_W-4){1'b0}}, res_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      enable_r    <= 1'b0;
      timeout_r   <= TIMEOUT_W'(30000);
      prep_hook_r <= 1'b0;
    end else if (cfg_valid) begin
      unique case (cfg_index)
        REG_ENABLE:    enable_r    <= cfg_data[0];
        REG_TIMEOUT:   timeout_r   <= cfg_data[TIMEOUT_W-1:0];
        REG_PREP_HOOK: prep_hook_r <= cfg_data[0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_tready) begin
      s1_valid_r <= in_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_item_r <= item_t'(in_tdata[4:0]);
      s1_kind_r <= in_tuser;
    end
  end

  always_comb begin
    logic [IDLE_BITS-1:0] idle_t;
    logic                 lit_t;
    logic                 act;
    lit_t    = lit_r;
    wait_nxt = wait_r;
    idle_t   = idle_r;
    hold_nxt = hold_r;
    touch_nxt = touch_r;
    act      = 1'b0;
    res_nxt  = '0;
    if (enable_r) begin
      case (s1_kind_r)
        KIND_TICK: begin
          if (idle_t != IDLE_MAX) idle_t = idle_t + 1'b1;
          act       = s1_item_r.touch_pressed && !touch_r;
          touch_nxt = s1_item_r.touch_pressed;
        end
        KIND_KEY: begin
          if (!s1_item_r.key_is_power) begin
            act = 1'b1;
          end else begin
            case (s1_item_r.key_event)
              KEV_CLICK: begin
                if (!lit_r && !wait_r) begin
                  act = 1'b1;
                end else if (!wait_r && !s1_item_r.capture_page_active) begin
                  lit_t  = !lit_r;
                  idle_t = '0;
                end
              end
              KEV_LONG: begin
                if (!wait_r) begin
                  wait_nxt = 1'b1;
                  res_nxt.shutdown_prepare = prep_hook_r;
                  lit_t = 1'b0;
                end
              end
              KEV_LONG_REL: res_nxt.power_off_request = wait_r;
              default: ;
            endcase
          end
        end
        KIND_MARK: act = 1'b1;
        KIND_HOLD: begin
          if (hold_r != HOLD_MAX) hold_nxt = hold_r + 1'b1;
          act = 1'b1;
        end
        KIND_RELEASE: begin
          if (hold_r != '0) begin
            hold_nxt = hold_r - 1'b1;
            idle_t   = '0;
          end
        end
        default: ;
      endcase
    end
    if (act) begin
      idle_t = '0;
      if (!lit_t && !wait_r) lit_t = 1'b1;
    end
    if (enable_r && (s1_kind_r == KIND_TICK) && (hold_r == '0) && lit_t &&
        (CMP_W'(idle_t) >= CMP_W'(timeout_r))) begin
      lit_t = 1'b0;
    end
    lit_nxt  = lit_t;
    idle_nxt = idle_t;
    res_nxt.screen_on        = lit_t;
    res_nxt.awaiting_release = wait_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lit_r   <= 1'b1;
      wait_r  <= 1'b0;
      idle_r  <= '0;
      hold_r  <= '0;
      touch_r <= 1'b0;
    end else if (s1_adv) begin
      lit_r   <= lit_nxt;
      wait_r  <= wait_nxt;
      idle_r  <= idle_nxt;
      hold_r  <= hold_nxt;
      touch_r <= touch_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (!out_valid_r || out_tready) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_adv) begin
      res_r <= res_nxt;
    end
  end

endmodule

// ===== rtl/core/sipkm_chk.sv =====
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sipkm_chk
// port-level checks for the screen idle and power key manager
// ----------------------------------------------------------------------------
module sipkm_chk
  import sipkm_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata
);

  // stalled word holds
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata))
    else $error("result word changed while stalled");

  a_rst_clear: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("result valid after reset");

  // fake-off keeps the screen dark
  a_wait_dark: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tdata[1] |-> !out_tdata[0])
    else $error("screen lit while awaiting release");

  a_pulses: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && (out_tdata[2] || out_tdata[3]) |-> out_tdata[1])
    else $error("pulse outside fake-off state");

endmodule

bind screen_idle_and_power_key_manager sipkm_chk u_sipkm_chk (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata)
);
